// ===== hdl/hce_pkg.sv =====
// Shared types, constants and letter decoding for the Hill cipher encryptor.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hce_pkg;

  localparam int LETTER_W = 5;

  localparam logic [LETTER_W-1:0] PAD_LETTER   = 5'd25;  // 'z'
  localparam logic [LETTER_W-1:0] SPACE_LETTER = 5'd13;  // 'n'
  localparam logic [6:0]          ASCII_LOWER_A = 7'd97;
  localparam logic [7:0]          ASCII_SPACE   = 8'h20;
  localparam int                  ALPHA_N       = 26;

  typedef struct packed {
    logic                ok;
    logic [LETTER_W-1:0] code;
  } letter_t;

  // Control that travels with each key/block read down the MAC pipeline.
  typedef struct packed {
    logic first;      // first term of a row sum
    logic last_term;  // last term of a row sum
    logic row_last;   // row is the last of the block
    logic msg_last;   // block closes the message
  } mac_ctl_t;

  typedef struct packed {
    logic [6:0] cipher_char;
    logic       block_end;
    logic       message_end;
  } out_item_t;

  function automatic letter_t letter_of(input logic [7:0] c);
    letter_t res;
    logic [7:0] diff;
    res  = '{ok: 1'b0, code: '0};
    diff = '0;
    if (c inside {[8'h61:8'h7a]}) begin
      diff = c - 8'h61;
      res  = '{ok: 1'b1, code: diff[LETTER_W-1:0]};
    end else if (c inside {[8'h41:8'h5a]}) begin
      diff = c - 8'h41;
      res  = '{ok: 1'b1, code: diff[LETTER_W-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hce_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/hce_mac.sv =====
// Multiply-accumulate pipeline: key entry times block letter, row sum, mod 26.
// Depends on hce_pkg; fed by the key and block RAM read ports.
`timescale 1ns / 1ps
`default_nettype none

module hce_mac #(
  parameter int MAX_ORDER = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                issue,
  input  wire hce_pkg::mac_ctl_t                   issue_ctl,
  input  wire logic                                issue_kvld,
  input  wire logic [hce_pkg::LETTER_W-1:0]        key_rdata,
  input  wire logic [hce_pkg::LETTER_W-1:0]        buf_rdata,
  output logic                                     push,
  output hce_pkg::out_item_t                       push_item
);

  localparam int PROD_W  = 2 * hce_pkg::LETTER_W;
  localparam int SUM_W   = $clog2(MAX_ORDER * 625 + 1);
  localparam int SHIFT   = SUM_W + 5;
  localparam int RECIP   = (2 ** SHIFT + hce_pkg::ALPHA_N - 1) / hce_pkg::ALPHA_N;
  localparam int RECIP_W = SHIFT - 4;
  localparam int QPROD_W = SUM_W + RECIP_W;
  localparam int QUO_W   = SUM_W - 4;
  localparam int LETTER_W_L = hce_pkg::LETTER_W;

  // stage 1: aligned with RAM read data
  logic                  v1_r;
  hce_pkg::mac_ctl_t     ctl1_r;
  logic                  kv1_r;
  // stage 2: product
  logic                  v2_r;
  hce_pkg::mac_ctl_t     ctl2_r;
  logic [PROD_W-1:0]     prod2_r;
  // stage 3: row sum
  logic [SUM_W-1:0]      acc_r;
  logic [SUM_W-1:0]      acc_nxt;
  logic                  v3_r;
  hce_pkg::mac_ctl_t     ctl3_r;
  logic [SUM_W-1:0]      sum3_r;
  // stage 4: quotient by 26
  logic                  v4_r;
  hce_pkg::mac_ctl_t     ctl4_r;
  logic [SUM_W-1:0]      sum4_r;
  logic [QUO_W-1:0]      quo4_r;

  logic [LETTER_W_L-1:0] key_term;
  logic [QPROD_W-1:0]    qprod;
  logic [SUM_W-1:0]      quo_x26;
  logic [SUM_W-1:0]      rem_full;
  logic [6:0]            cipher;

  assign key_term = kv1_r ? key_rdata : '0;
  assign acc_nxt  = (ctl2_r.first ? '0 : acc_r) + SUM_W'(prod2_r);
  assign qprod    = QPROD_W'(sum3_r) * QPROD_W'(RECIP);
  assign quo_x26  = SUM_W'(SUM_W'(quo4_r) * SUM_W'(hce_pkg::ALPHA_N));
  assign rem_full = sum4_r - quo_x26;
  assign cipher   = hce_pkg::ASCII_LOWER_A + 7'(rem_full[hce_pkg::LETTER_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r && ctl2_r.last_term;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl1_r  <= issue_ctl;
    kv1_r   <= issue_kvld;
    ctl2_r  <= ctl1_r;
    prod2_r <= PROD_W'(key_term * buf_rdata);
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    ctl3_r <= ctl2_r;
    sum3_r <= acc_nxt;
    ctl4_r <= ctl3_r;
    sum4_r <= sum3_r;
    quo4_r <= qprod[QPROD_W-1-(QPROD_W-SHIFT-QUO_W) -: QUO_W];
  end

  assign push = v4_r;
  assign push_item = '{cipher_char: cipher,
                       block_end:   ctl4_r.row_last,
                       message_end: ctl4_r.row_last && ctl4_r.msg_last};

endmodule

`default_nettype wire

// ===== hdl/hce_ofifo.sv =====
// Result queue between the MAC pipeline and the output channel.
// Depends on hce_pkg for the result item type.
`timescale 1ns / 1ps
`default_nettype none

module hce_ofifo #(
  parameter int DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hce_pkg::out_item_t push_item,
  input  wire logic               pop,
  output logic                    head_vld,
  output hce_pkg::out_item_t      head_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hce_pkg::out_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_vld  = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/hill_cipher_encryptor_top.sv =====
// Hill cipher encryptor: key character, message character, N*N reads per block.
// A key char runs a restoring pointer/N divide at pointer width, then a key write;
// a message char is written straight into the block buffer, and padding fills
// the rest of a short block with pad letters. A full block issues N*N key reads;
// each row of N reads yields one cipher letter, queued for the result channel.
// Reset clears control and key valid bits; block_order returns to 2.
`timescale 1ns / 1ps
`default_nettype none

module hill_cipher_encryptor_top #(
  parameter int MAX_ORDER = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last_char,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_cipher_char,
  output logic             out_block_end,
  output logic             out_message_end,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int OW     = $clog2(MAX_ORDER + 1);
  localparam int BAW    = $clog2(MAX_ORDER);
  localparam int KDEPTH = MAX_ORDER * MAX_ORDER;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int PTR_W  = $clog2(KDEPTH + 1);
  localparam int DCW    = $clog2(PTR_W);

  localparam logic       REG_BLOCK_ORDER = 1'b0;
  localparam logic [3:0] ORDER_RESET     = 4'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_MSG   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KDIV,
    S_KWR,
    S_PAD,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                  state_r,    state_nxt;
  logic [3:0]              order_r,    order_nxt;
  logic [KDEPTH-1:0]       kvld_r,     kvld_nxt;
  logic [PTR_W-1:0]        kptr_r,     kptr_nxt;
  logic [OW-1:0]           bcnt_r,     bcnt_nxt;
  logic                    msg_last_r, msg_last_nxt;
  logic [OW:0]             pend_r,     pend_nxt;
  logic [BAW-1:0]          row_r,      row_nxt;
  logic [BAW-1:0]          col_r,      col_nxt;
  logic [OW-1:0]           drem_r,     drem_nxt;
  logic [PTR_W-1:0]        dquo_r,     dquo_nxt;
  logic [DCW-1:0]          dcnt_r,     dcnt_nxt;
  logic [hce_pkg::LETTER_W-1:0] kchar_r, kchar_nxt;

  logic [OW-1:0]           n_eff;
  logic [PTR_W-1:0]        n_sq;
  logic                    in_fire;
  logic                    out_fire;
  logic                    cfg_wr;
  hce_pkg::letter_t        klet;
  hce_pkg::letter_t        mlet;
  logic [OW-1:0]           cnt_eff;
  logic [OW-1:0]           cnt_inc;
  logic [OW:0]             trial;
  logic                    col_last;
  logic                    row_last;

  logic                    key_we;
  logic [KAW-1:0]          key_waddr;
  logic [KAW-1:0]          key_raddr;
  logic [hce_pkg::LETTER_W-1:0] key_rdata;
  logic                    buf_we;
  logic [BAW-1:0]          buf_waddr;
  logic [hce_pkg::LETTER_W-1:0] buf_wdata;
  logic [hce_pkg::LETTER_W-1:0] buf_rdata;

  logic                    issue;
  hce_pkg::mac_ctl_t       issue_ctl;
  logic                    mac_push;
  hce_pkg::out_item_t      mac_item;
  hce_pkg::out_item_t      head_item;

  // order 0 acts as 1, values above the maximum act as the maximum
  always_comb begin
    if (order_r == 4'd0) begin
      n_eff = OW'(1);
    end else if (32'(order_r) > MAX_ORDER) begin
      n_eff = OW'(MAX_ORDER);
    end else begin
      n_eff = OW'(order_r);
    end
  end

  assign n_sq     = PTR_W'(32'(n_eff) * 32'(n_eff));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_BLOCK_ORDER);
  assign klet     = hce_pkg::letter_of(in_char_in);
  assign mlet     = (in_char_in == hce_pkg::ASCII_SPACE) ?
                    hce_pkg::letter_t'{ok: 1'b1, code: hce_pkg::SPACE_LETTER} : klet;
  assign cnt_eff  = (bcnt_r >= n_eff) ? '0 : bcnt_r;
  assign cnt_inc  = cnt_eff + OW'(1);
  assign trial    = {drem_r, dquo_r[PTR_W-1]};
  assign col_last = (OW'(col_r) + OW'(1) == n_eff);
  assign row_last = (OW'(row_r) + OW'(1) == n_eff);

  assign in_ready = (state_r == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_BLOCK_ORDER) ? {28'd0, order_r} : '0;

  assign key_waddr = KAW'(32'(dquo_r) * MAX_ORDER + 32'(drem_r));
  assign key_raddr = KAW'(32'(row_r) * MAX_ORDER + 32'(col_r));
  assign issue     = (state_r == S_EMIT);
  assign issue_ctl = '{first:     (col_r == '0),
                       last_term: col_last,
                       row_last:  row_last,
                       msg_last:  msg_last_r};

  always_comb begin
    state_nxt    = state_r;
    order_nxt    = cfg_wr ? pwdata[3:0] : order_r;
    kvld_nxt     = kvld_r;
    kptr_nxt     = kptr_r;
    bcnt_nxt     = bcnt_r;
    msg_last_nxt = msg_last_r;
    pend_nxt     = pend_r - ((OW+1)'(out_fire));
    row_nxt      = row_r;
    col_nxt      = col_r;
    drem_nxt     = drem_r;
    dquo_nxt     = dquo_r;
    dcnt_nxt     = dcnt_r;
    kchar_nxt    = kchar_r;
    key_we       = 1'b0;
    buf_we       = 1'b0;
    buf_waddr    = cnt_eff[BAW-1:0];
    buf_wdata    = mlet.code;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_operation))
            OP_CLEAR: begin
              kvld_nxt = '0;
              kptr_nxt = '0;
            end
            OP_KEY: begin
              if (klet.ok && (kptr_r < n_sq)) begin
                kchar_nxt = klet.code;
                drem_nxt  = '0;
                dquo_nxt  = kptr_r;
                dcnt_nxt  = DCW'(PTR_W - 1);
                state_nxt = S_KDIV;
              end
            end
            OP_MSG: begin
              bcnt_nxt = cnt_eff;
              if (mlet.ok) begin
                buf_we   = 1'b1;
                bcnt_nxt = cnt_inc;
                if (cnt_inc == n_eff) begin
                  msg_last_nxt = in_last_char;
                  state_nxt    = S_WAIT;
                end else if (in_last_char) begin
                  msg_last_nxt = 1'b1;
                  state_nxt    = S_PAD;
                end
              end else if (in_last_char && (cnt_eff != '0)) begin
                msg_last_nxt = 1'b1;
                state_nxt    = S_PAD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // restoring divide of the key pointer by N, one quotient bit a cycle
      S_KDIV: begin
        if (trial >= {1'b0, n_eff}) begin
          drem_nxt = OW'(trial - {1'b0, n_eff});
          dquo_nxt = {dquo_r[PTR_W-2:0], 1'b1};
        end else begin
          drem_nxt = OW'(trial);
          dquo_nxt = {dquo_r[PTR_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          state_nxt = S_KWR;
        end
      end

      S_KWR: begin
        key_we              = 1'b1;
        kvld_nxt[key_waddr] = 1'b1;
        kptr_nxt            = kptr_r + PTR_W'(1);
        state_nxt           = S_IDLE;
      end

      S_PAD: begin
        if (bcnt_r == n_eff) begin
          state_nxt = S_WAIT;
        end else begin
          buf_we    = 1'b1;
          buf_waddr = bcnt_r[BAW-1:0];
          buf_wdata = hce_pkg::PAD_LETTER;
          bcnt_nxt  = bcnt_r + OW'(1);
        end
      end

      // hold until the queue has room for the whole block
      S_WAIT: begin
        if (pend_r + {1'b0, n_eff} <= (OW+1)'(MAX_ORDER)) begin
          pend_nxt  = pend_r + {1'b0, n_eff} - ((OW+1)'(out_fire));
          bcnt_nxt  = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_r + BAW'(1);
          if (row_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          col_nxt = col_r + BAW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      order_r    <= ORDER_RESET;
      kvld_r     <= '0;
      kptr_r     <= '0;
      bcnt_r     <= '0;
      msg_last_r <= 1'b0;
      pend_r     <= '0;
      row_r      <= '0;
      col_r      <= '0;
      dcnt_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      order_r    <= order_nxt;
      kvld_r     <= kvld_nxt;
      kptr_r     <= kptr_nxt;
      bcnt_r     <= bcnt_nxt;
      msg_last_r <= msg_last_nxt;
      pend_r     <= pend_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      dcnt_r     <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drem_r  <= drem_nxt;
    dquo_r  <= dquo_nxt;
    kchar_r <= kchar_nxt;
  end

  hce_ram #(
    .WIDTH (hce_pkg::LETTER_W),
    .DEPTH (KDEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (kchar_r),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  hce_ram #(
    .WIDTH (hce_pkg::LETTER_W),
    .DEPTH (MAX_ORDER)
  ) u_blk_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (col_r),
    .rdata (buf_rdata)
  );

  hce_mac #(
    .MAX_ORDER (MAX_ORDER)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_ctl  (issue_ctl),
    .issue_kvld (kvld_r[key_raddr]),
    .key_rdata  (key_rdata),
    .buf_rdata  (buf_rdata),
    .push       (mac_push),
    .push_item  (mac_item)
  );

  hce_ofifo #(
    .DEPTH (MAX_ORDER)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mac_push),
    .push_item (mac_item),
    .pop       (out_fire),
    .head_vld  (out_valid),
    .head_item (head_item)
  );

  assign out_cipher_char = head_item.cipher_char;
  assign out_block_end   = head_item.block_end;
  assign out_message_end = head_item.message_end;

endmodule

`default_nettype wire

// ===== hdl/hce_checker.sv =====
// Port-level checks for the Hill cipher encryptor, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module hce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_cipher_char,
  input wire logic        out_block_end,
  input wire logic        out_message_end
);

  // a stalled result transfer keeps its letter
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_char)
                                && $stable(out_block_end) && $stable(out_message_end))
    else $error("result changed while stalled");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cipher_char >= 7'd97) && (out_cipher_char <= 7'd122))
    else $error("cipher letter out of range");

  a_msg_end_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_block_end)
    else $error("message end without block end");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind hill_cipher_encryptor_top hce_checker u_hce_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for hill_cipher_encryptor_top: drives key and message characters,
// predicts every cipher letter with an internal Hill cipher model and checks each output transfer.
// Depends on hdl/hce_pkg.sv and hdl/hill_cipher_encryptor_top.sv.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ORDER = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES = 120;
  localparam int PASS_ITEMS = 10;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_MSG   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] REG_BLOCK_ORDER = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_char_in;
  logic        in_last_char;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_cipher_char;
  logic        out_block_end;
  logic        out_message_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hill_cipher_encryptor_top #(.MAX_ORDER(MAX_ORDER)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_char_in      (in_char_in),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cipher_char (out_cipher_char),
    .out_block_end   (out_block_end),
    .out_message_end (out_message_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Cipher state mirrored from the block's behavior
  logic [hce_pkg::LETTER_W-1:0] key_mat [MAX_ORDER*MAX_ORDER];
  logic [hce_pkg::LETTER_W-1:0] blk_letters [MAX_ORDER];
  int                           key_ptr;
  int                           blk_fill;
  logic [3:0]                   order_reg;

  hce_pkg::out_item_t cipher_expect_q[$];

  int err_count;
  int items_sent;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("hill_cipher_encryptor_top regression: fail");
    $finish;
  end

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic int alpha_index(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 8'h61;
    if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 8'h41;
    return -1;
  endfunction

  function automatic int eff_order();
    if (order_reg == 4'd0) return 1;
    if (order_reg > MAX_ORDER) return MAX_ORDER;
    return int'(order_reg);
  endfunction

  function automatic logic [7:0] letter_byte();
    logic [7:0] base;
    base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // Multiply key rows by the buffered block and queue one letter per row
  function automatic void push_cipher_block(input int n, input logic last);
    hce_pkg::out_item_t w;
    int sum;
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int k = 0; k < n; k++)
        sum += int'(key_mat[i*MAX_ORDER + k]) * int'(blk_letters[k]);
      w.cipher_char = 7'(sum % hce_pkg::ALPHA_N) + hce_pkg::ASCII_LOWER_A;
      w.block_end   = (i == n - 1);
      w.message_end = last && (i == n - 1);
      cipher_expect_q.push_back(w);
    end
    blk_fill = 0;
  endfunction

  function automatic void encrypt_step(input logic [1:0] op, input logic [7:0] ch,
                                       input logic last);
    int n;
    int idx;
    n = eff_order();
    case (op)
      OP_CLEAR: begin
        foreach (key_mat[i]) key_mat[i] = '0;
        key_ptr = 0;
      end
      OP_KEY: begin
        idx = alpha_index(ch);
        if (idx >= 0 && key_ptr < n*n) begin
          key_mat[(key_ptr / n)*MAX_ORDER + key_ptr % n] = 5'(idx);
          key_ptr++;
        end
      end
      OP_MSG: begin
        // drop a stale partial block left over from a larger order
        if (blk_fill >= n) blk_fill = 0;
        idx = (ch == hce_pkg::ASCII_SPACE) ? int'(hce_pkg::SPACE_LETTER) : alpha_index(ch);
        if (idx >= 0) begin
          blk_letters[blk_fill] = 5'(idx);
          blk_fill++;
          if (blk_fill >= n) begin
            push_cipher_block(n, last);
            return;
          end
        end
        if (last && blk_fill > 0) begin
          while (blk_fill < n) begin
            blk_letters[blk_fill] = hce_pkg::PAD_LETTER;
            blk_fill++;
          end
          push_cipher_block(n, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one character; valid stays up across back-to-back transfers
  task automatic send_char(input logic [1:0] op, input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_char_in   <= ch;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    encrypt_step(op, ch, last);
    items_sent++;
  endtask

  // Drop valid, drain all letters, then give the block time to finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLOCK_ORDER;
    pwdata  <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    order_reg = value;
  endtask

  always @(posedge clk) begin
    hce_pkg::out_item_t got;
    hce_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.cipher_char = out_cipher_char;
        got.block_end   = out_block_end;
        got.message_end = out_message_end;
        if (cipher_expect_q.size() == 0) begin
          log_error($sformatf("unexpected letter %0d be=%0d me=%0d",
                              got.cipher_char, got.block_end, got.message_end));
        end else begin
          want = cipher_expect_q.pop_front();
          if (got !== want)
            log_error($sformatf("expected %0d be=%0d me=%0d, got %0d be=%0d me=%0d",
                                want.cipher_char, want.block_end, want.message_end,
                                got.cipher_char, got.block_end, got.message_end));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Order 2 after reset: key filtering, message filtering, padding corners
  task automatic test_directed_corners();
    send_char(OP_KEY, "A", 1'b0);
    send_char(OP_KEY, 8'h25, 1'b0);            // non-letter, skipped
    send_char(OP_KEY, "z", 1'b0);
    send_char(OP_KEY, 8'hff, 1'b1);
    send_char(OP_KEY, "M", 1'b1);              // last flag on key: no output
    send_char(OP_KEY, "q", 1'b0);
    send_char(OP_KEY, "B", 1'b0);              // matrix full, ignored
    send_char(OP_NONE, "x", 1'b1);
    send_char(OP_MSG, "H", 1'b0);
    send_char(OP_MSG, hce_pkg::ASCII_SPACE, 1'b0);
    send_char(OP_MSG, 8'h40, 1'b0);
    send_char(OP_MSG, 8'h5b, 1'b0);
    send_char(OP_MSG, 8'h60, 1'b0);
    send_char(OP_MSG, 8'h7b, 1'b0);
    send_char(OP_MSG, "y", 1'b0);
    send_char(OP_MSG, "Z", 1'b1);              // completes block on last
    send_char(OP_MSG, "k", 1'b0);
    send_char(OP_MSG, 8'h31, 1'b1);            // dropped, flushes with pad
    send_char(OP_MSG, 8'h00, 1'b1);            // dropped, nothing pending
    send_char(OP_MSG, hce_pkg::ASCII_SPACE, 1'b1);
    send_char(OP_MSG, "c", 1'b0);
    send_char(OP_CLEAR, 8'hff, 1'b1);          // partial block survives clear
    send_char(OP_KEY, "b", 1'b0);
    send_char(OP_MSG, "d", 1'b0);
    send_char(OP_MSG, "a", 1'b1);
  endtask

  // One configuration, optional fresh key, then a message with noise
  task automatic run_session(input logic [3:0] cfg);
    int n;
    int key_len;
    int msg_len;
    logic [1:0] op;
    logic [7:0] ch;
    logic last;
    settle();
    write_order(cfg);
    n = eff_order();
    if ($urandom_range(0, 3) != 0) begin
      send_char(OP_CLEAR, 8'($urandom), 1'($urandom));
      if (n*n <= 16 || $urandom_range(0, 3) == 0) key_len = n*n + $urandom_range(0, 2);
      else key_len = $urandom_range(n, n*n);
      for (int j = 0; j < key_len; j++) begin
        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : letter_byte();
        send_char(OP_KEY, ch, $urandom_range(0, 15) == 0);
      end
    end else begin
      // keep the old key, possibly filled at another order
      repeat ($urandom_range(0, 3)) send_char(OP_KEY, letter_byte(), 1'b0);
    end
    msg_len = $urandom_range(1, 3*n);
    for (int j = 0; j < msg_len; j++) begin
      op = OP_MSG;
      case ($urandom_range(0, 19))
        0: begin
          op = OP_NONE;
          ch = 8'($urandom);
        end
        1: ch = hce_pkg::ASCII_SPACE;
        2: ch = 8'($urandom);
        default: ch = letter_byte();
      endcase
      if (j == msg_len - 1) last = ($urandom_range(0, 3) != 0);
      else last = ($urandom_range(0, 24) == 0);
      send_char(op, ch, last);
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [3:0] first_cfg,
                                     input logic [3:0] second_cfg);
    int start;
    logic [3:0] cfg;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    start = items_sent;
    run_session(first_cfg);
    run_session(second_cfg);
    while (items_sent - start < PASS_ITEMS) begin
      if ($urandom_range(0, 4) == 0) cfg = 4'($urandom_range(0, 15));
      else cfg = 4'($urandom_range(1, 4));
      run_session(cfg);
    end
  endtask

  // Hold the output off for a long stretch while the sender keeps pushing letters
  task automatic test_output_backpressure();
    int saved_gap;
    settle();
    write_order(4'd8);
    send_char(OP_CLEAR, 8'h00, 1'b0);
    repeat (16) send_char(OP_KEY, letter_byte(), 1'b0);
    saved_gap = send_gap_pct;
    send_gap_pct = 0;
    hold_left = 400;
    for (int j = 0; j < 24; j++) send_char(OP_MSG, letter_byte(), j == 23);
    send_gap_pct = saved_gap;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_NONE;
    in_char_in   <= 8'h00;
    in_last_char <= 1'b0;
    out_ready    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= REG_BLOCK_ORDER;
    pwdata       <= 32'd0;
    foreach (key_mat[i]) key_mat[i] = '0;
    foreach (blk_letters[i]) blk_letters[i] = '0;
    key_ptr      = 0;
    blk_fill     = 0;
    order_reg    = 4'd2;
    err_count    = 0;
    items_sent   = 0;
    hold_left    = 0;
    send_gap_pct = 22;
    recv_gap_pct = 58;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_traffic(22, 58, 4'd1, 4'd8);
    test_random_traffic(58, 22, 4'd0, 4'd15);
    test_output_backpressure();
    test_random_traffic(0, 0, 4'd3, 4'($urandom_range(1, 8)));

    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("hill_cipher_encryptor_top regression: pass");
    end else begin
      $display("hill_cipher_encryptor_top regression: fail");
    end
    $finish;
  end

endmodule
